@@ sv/aes_block_cipher_ecb_defines.svh @@
// Assertion macros used by the checker file.
`ifndef AES_BLOCK_CIPHER_ECB_DEFINES_SVH
`define AES_BLOCK_CIPHER_ECB_DEFINES_SVH

// Any property, reset-qualified.
`define AES_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Antecedent one cycle, consequent the next.
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/aesecb_pkg.sv @@
`default_nettype none
package aesecb_pkg;

  localparam int unsigned MAX_KEY_WORDS_DEF = 8;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [2:0] CFG_KEY_SIZE_MODE = 3'd0;
  localparam logic [2:0] CFG_KEY_PART_0    = 3'd1;
  localparam logic [2:0] CFG_KEY_PART_3    = 3'd4;

  localparam logic [1:0] KSM_128 = 2'd0;
  localparam logic [1:0] KSM_192 = 2'd1;
  localparam logic [1:0] KSM_256 = 2'd2;
  localparam logic [1:0] KSM_RSVD = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ADD0,
    ST_ROUND,
    ST_DONE
  } state_e;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,
    8'hfe,8'hd7,8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
    8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,
    8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,
    8'heb,8'h27,8'hb2,8'h75,8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
    8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,
    8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,
    8'h50,8'h3c,8'h9f,8'ha8,8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
    8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,8'hcd,8'h0c,8'h13,8'hec,
    8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,
    8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
    8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,
    8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,
    8'h4b,8'hbd,8'h8b,8'h8a,8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
    8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,8'he1,8'hf8,8'h98,8'h11,
    8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,
    8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,
    8'h81,8'hf3,8'hd7,8'hfb,8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
    8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,8'h54,8'h7b,8'h94,8'h32,
    8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,
    8'h6d,8'h8b,8'hd1,8'h25,8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
    8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,8'h6c,8'h70,8'h48,8'h50,
    8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,
    8'hb8,8'hb3,8'h45,8'h06,8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
    8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,8'h3a,8'h91,8'h11,8'h41,
    8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,
    8'h1c,8'h75,8'hdf,8'h6e,8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
    8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,8'hfc,8'h56,8'h3e,8'h4b,
    8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,
    8'h27,8'h80,8'hec,8'h5f,8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
    8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,8'ha0,8'he0,8'h3b,8'h4d,
    8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,
    8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
  endfunction

  // Column mix; byte r of the column sits in bits [31-8r -: 8].
  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m0 [4];
    logic [31:0] o;
    for (int k = 0; k < 4; k++) begin
      a[k]  = col[31-8*k -: 8];
      x2[k] = xt(a[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
      if (inv) begin
        m0[k] = x8[k] ^ x4[k] ^ x2[k];  // 0e
        m1[k] = x8[k] ^ x2[k] ^ a[k];   // 0b
        m2[k] = x8[k] ^ x4[k] ^ a[k];   // 0d
        m3[k] = x8[k] ^ a[k];           // 09
      end else begin
        m0[k] = x2[k];
        m1[k] = x2[k] ^ a[k];
        m2[k] = a[k];
        m3[k] = a[k];
      end
    end
    for (int r = 0; r < 4; r++) begin
      o[31-8*r -: 8] = m0[r] ^ m1[(r+1)%4] ^ m2[(r+2)%4] ^ m3[(r+3)%4];
    end
    return o;
  endfunction

  // One cipher round; state byte j in bits [127-8j -: 8], column c = bytes 4c..4c+3.
  function automatic logic [127:0] do_round(input logic [127:0] s, input logic [127:0] rk,
                                            input logic inv, input logic last);
    logic [127:0] t;
    logic [7:0]   v;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          v = s[127-8*(((c+4-r)%4)*4+r) -: 8];
          t[127-8*(c*4+r) -: 8] = SBOX_INV[v];
        end else begin
          v = s[127-8*(((c+r)%4)*4+r) -: 8];
          t[127-8*(c*4+r) -: 8] = SBOX_FWD[v];
        end
      end
    end
    if (inv) begin
      t = t ^ rk;
      if (!last) begin
        for (int c = 0; c < 4; c++) t[127-32*c -: 32] = mix_col(t[127-32*c -: 32], 1'b1);
      end
    end else begin
      if (!last) begin
        for (int c = 0; c < 4; c++) t[127-32*c -: 32] = mix_col(t[127-32*c -: 32], 1'b0);
      end
      t = t ^ rk;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

@@ sv/aes_block_cipher_ecb.sv @@
`default_nettype none
// Channel | Handshake                  | Payload
// --------+----------------------------+--------------------------------------
// in      | in_valid_i / in_ready_o    | opcode_i, block_high_i, block_low_i
// out     | out_valid_o / out_ready_i  | result_high_o, result_low_o
// cfg     | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// A result is offered after its item is taken and passes these steps: one load of the round-key
// store, the initial key addition, one round per cycle through the shared round unit, then
// the output step. No new item is taken until the last one has left the output step. The
// store has a single registered read port, one row per round. The first item after reset
// or a mode or key write first runs key expansion of 4*(Nr+1) words, one word per cycle.
// Reset clears control and configuration state only; the store is filled by expansion.
// Results sit in an output register: in_ready_o does not wait for out_ready_i, but a
// finished item waits in the last step while an earlier result is still unread.
module aes_block_cipher_ecb #(
  parameter int unsigned MAX_KEY_WORDS = aesecb_pkg::MAX_KEY_WORDS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i
);

  localparam int unsigned Rows = MAX_KEY_WORDS + 7;  // round-key rows
  localparam int unsigned AW   = $clog2(Rows);
  localparam int unsigned WW   = AW + 2;             // word counter
  localparam int unsigned IW   = $clog2(MAX_KEY_WORDS);

  // configuration registers
  logic [1:0]  mode_q;
  logic [63:0] key_q [4];
  logic        sched_valid_q;

  // sequencer
  aesecb_pkg::state_e state_q, state_d;
  logic        op_q;
  logic [127:0] st_q;
  logic [AW-1:0] cnt_q;
  logic [AW-1:0] nr_q;
  logic [3:0]  nk_q;

  // key expansion
  logic [WW-1:0] wi_q;
  logic [3:0]  modk_q;
  logic [7:0]  rc_q;
  logic [31:0] win_q [MAX_KEY_WORDS];
  logic [95:0] acc_q;

  // round-key store
  logic [127:0] mem [Rows];
  logic [127:0] rk_q;
  logic [AW-1:0] rd_addr;
  logic         wr_en;

  logic        out_valid_q;
  logic [127:0] res_q;

  logic        in_acc;
  logic        last_round;
  logic        last_word;
  logic        out_free;
  logic [3:0]  nk_pick;
  logic [3:0]  nkm1;
  logic [31:0] new_word;
  logic [31:0] key_word;
  logic [31:0] prev_w;
  logic [31:0] tw;
  logic [AW-1:0] next_k;

  assign in_acc     = in_valid_i && in_ready_o;
  assign last_round = (cnt_q == nr_q);
  assign last_word  = (wi_q[WW-1:2] == nr_q) && (wi_q[1:0] == 2'd3);
  assign out_free   = !out_valid_q || out_ready_i;

  // Key length after the parameter cap; the reserved mode is stored as 256-bit.
  always_comb begin
    case (mode_q)
      aesecb_pkg::KSM_128: nk_pick = 4'd4;
      aesecb_pkg::KSM_192: nk_pick = (MAX_KEY_WORDS >= 6) ? 4'd6 : 4'd4;
      default:             nk_pick = (MAX_KEY_WORDS >= 8) ? 4'd8 :
                                     (MAX_KEY_WORDS >= 6) ? 4'd6 : 4'd4;
    endcase
  end

  // next schedule word
  assign nkm1     = nk_q - 4'd1;
  assign prev_w   = win_q[0];
  assign key_word = wi_q[0] ? key_q[wi_q[2:1]][31:0] : key_q[wi_q[2:1]][63:32];
  always_comb begin
    if (modk_q == 4'd0) begin
      tw = aesecb_pkg::sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rc_q, 24'd0};
    end else if (nk_q == 4'd8 && modk_q == 4'd4) begin
      tw = aesecb_pkg::sub_word(prev_w);
    end else begin
      tw = prev_w;
    end
    if ({{(8-WW){1'b0}}, wi_q} < {4'd0, nk_q}) begin
      new_word = key_word;
    end else begin
      new_word = win_q[nkm1[IW-1:0]] ^ tw;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      aesecb_pkg::ST_IDLE:   if (in_valid_i) begin
        state_d = sched_valid_q ? aesecb_pkg::ST_LOAD : aesecb_pkg::ST_EXPAND;
      end
      aesecb_pkg::ST_EXPAND: if (last_word) state_d = aesecb_pkg::ST_LOAD;
      aesecb_pkg::ST_LOAD:   state_d = aesecb_pkg::ST_ADD0;
      aesecb_pkg::ST_ADD0:   state_d = aesecb_pkg::ST_ROUND;
      aesecb_pkg::ST_ROUND:  if (last_round) state_d = aesecb_pkg::ST_DONE;
      aesecb_pkg::ST_DONE:   if (out_free) state_d = aesecb_pkg::ST_IDLE;
      default:               state_d = aesecb_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, store read address and write enable
  always_comb begin
    in_ready_o = 1'b0;
    wr_en      = 1'b0;
    rd_addr    = '0;
    next_k     = '0;
    case (state_q)
      aesecb_pkg::ST_IDLE:   in_ready_o = 1'b1;
      aesecb_pkg::ST_EXPAND: wr_en = (wi_q[1:0] == 2'd3);
      aesecb_pkg::ST_LOAD:   rd_addr = (op_q == aesecb_pkg::OP_DECRYPT) ? nr_q : '0;
      aesecb_pkg::ST_ADD0: begin
        next_k  = {{(AW-1){1'b0}}, 1'b1};
        rd_addr = (op_q == aesecb_pkg::OP_DECRYPT) ? nr_q - next_k : next_k;
      end
      aesecb_pkg::ST_ROUND: begin
        next_k = cnt_q + {{(AW-1){1'b0}}, 1'b1};
        if (!last_round) begin
          rd_addr = (op_q == aesecb_pkg::OP_DECRYPT) ? nr_q - next_k : next_k;
        end
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // round-key store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wi_q[WW-1:2]] <= {acc_q, new_word};
    rk_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= aesecb_pkg::ST_IDLE;
      mode_q        <= aesecb_pkg::KSM_128;
      sched_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
      nk_q          <= 4'd4;
      nr_q          <= AW'(10);
      cnt_q         <= '0;
      wi_q          <= '0;
      modk_q        <= '0;
      rc_q          <= 8'h01;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        if (cfg_idx_i == aesecb_pkg::CFG_KEY_SIZE_MODE) begin
          mode_q <= (cfg_wdata_i[1:0] == aesecb_pkg::KSM_RSVD) ? aesecb_pkg::KSM_256
                                                                : cfg_wdata_i[1:0];
          sched_valid_q <= 1'b0;
        end else if (cfg_idx_i <= aesecb_pkg::CFG_KEY_PART_3) begin
          key_q[2'(cfg_idx_i - aesecb_pkg::CFG_KEY_PART_0)] <= cfg_wdata_i;
          sched_valid_q <= 1'b0;
        end
      end

      if (in_acc && !sched_valid_q) begin
        nk_q   <= nk_pick;
        nr_q   <= AW'(nk_pick + 4'd6);
        wi_q   <= '0;
        modk_q <= '0;
        rc_q   <= 8'h01;
      end

      if (state_q == aesecb_pkg::ST_EXPAND) begin
        wi_q   <= wi_q + {{(WW-1){1'b0}}, 1'b1};
        modk_q <= (modk_q == nkm1) ? 4'd0 : modk_q + 4'd1;
        if (modk_q == 4'd0 && {{(8-WW){1'b0}}, wi_q} >= {4'd0, nk_q}) begin
          rc_q <= aesecb_pkg::xt(rc_q);
        end
        if (last_word) sched_valid_q <= 1'b1;
      end

      if (state_q == aesecb_pkg::ST_ADD0)  cnt_q <= {{(AW-1){1'b0}}, 1'b1};
      if (state_q == aesecb_pkg::ST_ROUND) cnt_q <= next_k;

      if (state_q == aesecb_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= opcode_i;
      st_q <= {block_high_i, block_low_i};
    end
    if (state_q == aesecb_pkg::ST_EXPAND) begin
      win_q[0] <= new_word;
      for (int k = 1; k < MAX_KEY_WORDS; k++) win_q[k] <= win_q[k-1];
      acc_q <= {acc_q[63:0], new_word};
    end
    if (state_q == aesecb_pkg::ST_ADD0) st_q <= st_q ^ rk_q;
    if (state_q == aesecb_pkg::ST_ROUND) begin
      st_q <= aesecb_pkg::do_round(st_q, rk_q, op_q == aesecb_pkg::OP_DECRYPT, last_round);
    end
    if (state_q == aesecb_pkg::ST_DONE && out_free) res_q <= st_q;
  end

  assign out_valid_o   = out_valid_q;
  assign result_high_o = res_q[127:64];
  assign result_low_o  = res_q[63:0];

endmodule
`default_nettype wire

@@ sv/aesecb_checker.sv @@
`default_nettype none
`include "aes_block_cipher_ecb_defines.svh"
module aesecb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] result_high_o,
  input wire logic [63:0] result_low_o
);

  // a waiting result stays offered
  `AES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // an accepted item leaves the block busy, with in_ready_o low
  `AES_ASSERT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o |-> ##1 !in_ready_o ##1 !in_ready_o)

  // result data only changes when a new result replaces a taken or empty one
  `AES_ASSERT(a_res_stable, clk_i, rst_ni, $past(out_valid_o && !out_ready_i) |-> $stable(result_high_o) && $stable(result_low_o))

endmodule

bind aes_block_cipher_ecb aesecb_checker u_aesecb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .result_high_o(result_high_o),
  .result_low_o (result_low_o)
);
`default_nettype wire
